// ===== src/mse_pkg.sv =====
// Shared types and constants for the merge sort engine.
package mse_pkg;

  localparam int DATA_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_SETUP,
    ST_MERGE,
    ST_OUT_SETUP,
    ST_OUT
  } state_t;

endpackage

// ===== src/mse_stream_if.sv =====
// Valid/ready stream channel carrying one payload of type T per transaction.
interface mse_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/mse_ram.sv =====
// Simple dual-read, single-write RAM with registered read data.
module mse_ram #(
  parameter int DEPTH  = mse_pkg::MAX_ELEMENTS_DEF,
  parameter int WIDTH  = mse_pkg::DATA_W,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [WIDTH-1:0]  rdata0,
  output logic [WIDTH-1:0]  rdata1
);
  import mse_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== src/merge_sort_engine_top.sv =====
// Top level of the merge sort engine: load, bottom-up merge passes, ordered output.
// Load stores each accepted transaction; after the last item the sort runs
//   ceil(log2 n) passes, each a pass-setup step followed by merging one element per
//   cycle, then an output-setup step hands results to the output register at one
//   result per cycle while out_ch.ready is held high.
// Throughput is set by the single write port of the ping-pong buffers.
// Reset (rst_n, synchronous, active low) empties the set and the output register.
module merge_sort_engine_top #(
  parameter int MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mse_stream_if.sink   in_ch,
  mse_stream_if.source out_ch
);
  import mse_pkg::*;

  // index bits, count bits (holds MAX_ELEMENTS itself), run-bound sum bits
  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int W_W   = CNT_W + 1;
  localparam int SUM_W = CNT_W + 2;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;   // values stored in the current set
  logic [CNT_W-1:0] n_r, n_nxt;           // set size frozen at sort start
  logic [W_W-1:0]   w_r, w_nxt;           // run width of the current pass
  logic             src_sel_r, src_sel_nxt; // 0: buffer A is source, 1: buffer B
  logic [CNT_W-1:0] i_r, i_nxt;           // left run cursor / output cursor
  logic [CNT_W-1:0] j_r, j_nxt;           // right run cursor
  logic [CNT_W-1:0] k_r, k_nxt;           // merge write cursor
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // RAM ports
  logic              we_a, we_b;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
  logic [DATA_W-1:0] rd_left, rd_right;

  // merge helpers
  logic             take_left;
  logic [SUM_W-1:0] run_lo, mid_sum, hi_sum, n_ext;
  logic [CNT_W-1:0] mid_cl, hi_cl;
  logic [CNT_W-1:0] k_inc, i_inc, fill;
  logic [W_W-1:0]   w_dbl;
  logic             in_fire;

  // Ping-pong buffers; both read at the cursors' next values so the registered
  // data lines up with i_r / j_r in the following cycle.
  mse_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(DATA_W), .ADDR_W(IDX_W)) u_buf_a (
    .clk    (clk),
    .we     (we_a),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (i_nxt[IDX_W-1:0]),
    .raddr1 (j_nxt[IDX_W-1:0]),
    .rdata0 (rd_a0),
    .rdata1 (rd_a1)
  );

  mse_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(DATA_W), .ADDR_W(IDX_W)) u_buf_b (
    .clk    (clk),
    .we     (we_b),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (i_nxt[IDX_W-1:0]),
    .raddr1 (j_nxt[IDX_W-1:0]),
    .rdata0 (rd_b0),
    .rdata1 (rd_b1)
  );

  assign rd_left  = src_sel_r ? rd_b0 : rd_a0;
  assign rd_right = src_sel_r ? rd_b1 : rd_a1;

  assign in_ch.ready  = (state_r == ST_LOAD);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Left run wins ties, which keeps the sort stable.
  assign take_left = (i_r < mid_r) &&
                     ((j_r >= hi_r) || ($signed(rd_left) <= $signed(rd_right)));

  // Bounds of the next run: starts at 0 in pass setup, at the old hi mid-pass.
  assign run_lo  = (state_r == ST_MERGE) ? SUM_W'(hi_r) : '0;
  assign mid_sum = run_lo + SUM_W'(w_r);
  assign hi_sum  = run_lo + SUM_W'(w_r) + SUM_W'(w_r);
  assign n_ext   = SUM_W'(n_r);
  assign mid_cl  = (mid_sum > n_ext) ? n_r : mid_sum[CNT_W-1:0];
  assign hi_cl   = (hi_sum > n_ext) ? n_r : hi_sum[CNT_W-1:0];

  assign k_inc = k_r + CNT_W'(1);
  assign i_inc = i_r + CNT_W'(1);
  assign fill  = count_r + CNT_W'(1);
  assign w_dbl = w_r << 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    w_r        <= w_nxt;
    src_sel_r  <= src_sel_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    mid_r      <= mid_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    src_sel_nxt   = src_sel_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    we_a          = 1'b0;
    we_b          = 1'b0;
    waddr         = k_r[IDX_W-1:0];
    wdata         = take_left ? rd_left : rd_right;

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (count_r < CNT_W'(MAX_ELEMENTS)) begin
            we_a      = 1'b1;
            waddr     = count_r[IDX_W-1:0];
            wdata     = in_ch.data.value;
            count_nxt = fill;
          end
          if (in_ch.data.is_last) begin
            // set size includes this transaction if it was stored
            n_nxt       = (count_r < CNT_W'(MAX_ELEMENTS)) ? fill : count_r;
            count_nxt   = '0;
            w_nxt       = W_W'(1);
            src_sel_nxt = 1'b0;
            state_nxt   = (n_nxt == CNT_W'(1)) ? ST_OUT_SETUP : ST_PASS_SETUP;
          end
        end
      end

      ST_PASS_SETUP: begin
        i_nxt     = '0;
        j_nxt     = mid_cl;
        k_nxt     = '0;
        mid_nxt   = mid_cl;
        hi_nxt    = hi_cl;
        state_nxt = ST_MERGE;
      end

      ST_MERGE: begin
        we_a  = src_sel_r;
        we_b  = !src_sel_r;
        k_nxt = k_inc;
        if (take_left) begin
          i_nxt = i_inc;
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
        if (k_inc == hi_r) begin
          if (hi_r == n_r) begin
            // pass complete: swap buffers, double the run width
            src_sel_nxt = !src_sel_r;
            w_nxt       = w_dbl;
            state_nxt   = (w_dbl >= W_W'(n_r)) ? ST_OUT_SETUP : ST_PASS_SETUP;
          end else begin
            i_nxt   = hi_r;
            j_nxt   = mid_cl;
            mid_nxt = mid_cl;
            hi_nxt  = hi_cl;
          end
        end
      end

      ST_OUT_SETUP: begin
        i_nxt     = '0;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.sorted_value = rd_left;
          out_data_nxt.last_out     = (i_inc == n_r);
          if (i_inc == n_r) begin
            state_nxt = ST_LOAD;
          end else begin
            i_nxt = i_inc;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Merge write cursor stays inside the set.
  a_merge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (k_r < n_r))
    else $error("merge write cursor beyond set size");

  // Each merge cycle has an element to take from one of the two runs.
  a_merge_has_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> ((i_r < mid_r) || (j_r < hi_r)))
    else $error("merge step with both runs exhausted");

  // Stored count never exceeds capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above capacity");

  // Loading the final result returns the engine to accepting a new set.
  a_last_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUT) && out_valid_nxt && !(out_valid_r && !out_ch.ready)
     && (i_inc == n_r)) |=> (state_r == ST_LOAD))
    else $error("engine did not return to load after final result");

endmodule
